/* hw/rtl/pish_pkg.sv */
// Shared constants and types for the point-in-shapes hit test block.
package pish_pkg;

   // Default sizing, handed to the top level parameters
   localparam int DEF_MAX_FIGURES = 16;
   localparam int DEF_COORD_WIDTH = 24;

   // Fixed result field widths
   localparam int STATUS_W    = 2;
   localparam int POINT_NUM_W = 32;
   localparam int FIG_NUM_W   = 7;

   typedef logic [STATUS_W-1:0]    status_type;
   typedef logic [POINT_NUM_W-1:0] point_num_type;
   typedef logic [FIG_NUM_W-1:0]   fig_num_type;

   // Result status codes
   localparam status_type STATUS_INSIDE  = 2'd0;
   localparam status_type STATUS_OUTSIDE = 2'd1;
   localparam status_type STATUS_REJECT  = 2'd2;

   // Request function and figure kind codes
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;
   localparam logic KIND_RECT   = 1'b0;
   localparam logic KIND_CIRCLE = 1'b1;

endpackage

/* hw/rtl/point_in_shapes_hit_test.sv */
// Top level of the point-in-shapes hit test: figure table, sequencer and shared multiplier.
//
//   channel   ports                        handshake
//   -------   --------------------------   ----------------------------------
//   request   req_* fields                 beat taken when start && !busy
//   result    rsp_* fields                 one beat per cycle with rsp_valid high
//
// A load leaves busy low; a rejected load puts its beat out on the next cycle.
// A query holds busy while the sequencer steps through the stored figures: the
// figure memory read and the difference step, then for circles three passes
// through the single shared multiplier and a compare, and a final result step.
// Reset clears the figure count and the query number; table entries are not cleared.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module point_in_shapes_hit_test #(
   parameter int MAX_FIGURES = pish_pkg::DEF_MAX_FIGURES,
   parameter int COORD_WIDTH = pish_pkg::DEF_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_func,
   input  logic                          req_kind,
   input  logic signed [COORD_WIDTH-1:0] req_anchor_x,
   input  logic signed [COORD_WIDTH-1:0] req_anchor_y,
   input  logic signed [COORD_WIDTH-1:0] req_corner_x,
   input  logic signed [COORD_WIDTH-1:0] req_corner_y,
   input  logic        [COORD_WIDTH-2:0] req_circle_radius,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   output logic                          rsp_valid,
   output pish_pkg::status_type          rsp_status,
   output pish_pkg::point_num_type       rsp_point_number,
   output pish_pkg::fig_num_type         rsp_figure_number,
   output logic                          rsp_last
);
   import pish_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int IDX_W = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1;
   localparam int CNT_W = $clog2(MAX_FIGURES + 1);
   localparam int PRD_W = 2 * CW;
   localparam int ACC_W = 2 * CW + 1;
   localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(MAX_FIGURES);

   // Sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_DIFF   = 3'd2;
   localparam logic [2:0] ST_MUL_X  = 3'd3;
   localparam logic [2:0] ST_MUL_Y  = 3'd4;
   localparam logic [2:0] ST_MUL_R  = 3'd5;
   localparam logic [2:0] ST_CMP    = 3'd6;
   localparam logic [2:0] ST_FINISH = 3'd7;

   // Figure table
   logic                 mem_circle   [0:MAX_FIGURES-1];
   logic signed [CW-1:0] mem_anchor_x [0:MAX_FIGURES-1];
   logic signed [CW-1:0] mem_anchor_y [0:MAX_FIGURES-1];
   logic signed [CW-1:0] mem_corner_x [0:MAX_FIGURES-1];
   logic signed [CW-1:0] mem_corner_y [0:MAX_FIGURES-1];
   logic        [CW-2:0] mem_radius   [0:MAX_FIGURES-1];

   logic                 rd_circle_ff;
   logic signed [CW-1:0] rd_anchor_x_ff;
   logic signed [CW-1:0] rd_anchor_y_ff;
   logic signed [CW-1:0] rd_corner_x_ff;
   logic signed [CW-1:0] rd_corner_y_ff;
   logic        [CW-2:0] rd_radius_ff;

   // Control and datapath registers
   logic [2:0]           state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   point_num_type        qnum_ff, qnum_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [CNT_W-1:0]     pend_fig_ff, pend_fig_in;
   logic signed [CW-1:0] px_ff, px_in;
   logic signed [CW-1:0] py_ff, py_in;
   logic [CW-1:0]        dx_ff, dx_in;
   logic [CW-1:0]        dy_ff, dy_in;
   logic [PRD_W-1:0]     prod_ff, prod_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   point_num_type        rsp_pnum_ff, rsp_pnum_in;
   fig_num_type          rsp_fig_ff, rsp_fig_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 accept;
   logic                 load_ok;
   logic [IDX_W-1:0]     wr_idx;
   logic [CNT_W-1:0]     idx_next_cnt;
   logic signed [CW:0]   diff_x;
   logic signed [CW:0]   diff_y;
   logic [CW:0]          mag_x;
   logic [CW:0]          mag_y;
   logic                 rect_hit;
   logic                 eval_en;
   logic                 eval_hit;
   logic [CW-1:0]        mul_a;
   logic [CW-1:0]        mul_b;
   logic [PRD_W-1:0]     mul_p;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign load_ok = accept && (req_func == FUNC_LOAD) && (count_ff != COUNT_FULL);
   assign wr_idx  = IDX_W'(count_ff);

   // Write a loaded figure; read the figure under test into registers
   always_ff @(posedge clock) begin
      if (load_ok) begin
         mem_circle[wr_idx]   <= (req_kind == KIND_CIRCLE);
         mem_anchor_x[wr_idx] <= req_anchor_x;
         mem_anchor_y[wr_idx] <= req_anchor_y;
         mem_corner_x[wr_idx] <= req_corner_x;
         mem_corner_y[wr_idx] <= req_corner_y;
         mem_radius[wr_idx]   <= req_circle_radius;
      end
      if (state_ff == ST_READ) begin
         rd_circle_ff   <= mem_circle[idx_ff];
         rd_anchor_x_ff <= mem_anchor_x[idx_ff];
         rd_anchor_y_ff <= mem_anchor_y[idx_ff];
         rd_corner_x_ff <= mem_corner_x[idx_ff];
         rd_corner_y_ff <= mem_corner_y[idx_ff];
         rd_radius_ff   <= mem_radius[idx_ff];
      end
   end

   // Absolute distances to the circle center and the rectangle test
   assign diff_x = {px_ff[CW-1], px_ff} - {rd_anchor_x_ff[CW-1], rd_anchor_x_ff};
   assign diff_y = {py_ff[CW-1], py_ff} - {rd_anchor_y_ff[CW-1], rd_anchor_y_ff};
   assign mag_x  = diff_x[CW] ? (~diff_x + 1'b1) : diff_x;
   assign mag_y  = diff_y[CW] ? (~diff_y + 1'b1) : diff_y;
   assign rect_hit = (rd_anchor_x_ff < px_ff) && (rd_corner_x_ff > px_ff) &&
                     (rd_anchor_y_ff > py_ff) && (rd_corner_y_ff < py_ff);

   // Shared multiplier: pick operands by step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MUL_X: begin
            mul_a = dx_ff;
            mul_b = dx_ff;
         end
         ST_MUL_Y: begin
            mul_a = dy_ff;
            mul_b = dy_ff;
         end
         ST_MUL_R: begin
            mul_a = {1'b0, rd_radius_ff};
            mul_b = {1'b0, rd_radius_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // One figure's verdict is known at the rectangle compare or the circle compare
   assign eval_en  = ((state_ff == ST_DIFF) && !rd_circle_ff) || (state_ff == ST_CMP);
   assign eval_hit = (state_ff == ST_CMP) ? (acc_ff < {1'b0, prod_ff}) : rect_hit;
   assign idx_next_cnt = CNT_W'(idx_ff) + CNT_W'(1);

   // Sequencer and result beats
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      qnum_in       = qnum_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pend_fig_in   = pend_fig_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_pnum_in   = rsp_pnum_ff;
      rsp_fig_in    = rsp_fig_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_LOAD) begin
                  if (count_ff == COUNT_FULL) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_REJECT;
                     rsp_pnum_in   = '0;
                     rsp_fig_in    = '0;
                     rsp_last_in   = 1'b1;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  qnum_in = qnum_ff + POINT_NUM_W'(1);
                  px_in   = req_point_x;
                  py_in   = req_point_y;
                  idx_in  = '0;
                  pend_in = 1'b0;
                  state_in = (count_ff == '0) ? ST_FINISH : ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            dx_in = mag_x[CW-1:0];
            dy_in = mag_y[CW-1:0];
            if (rd_circle_ff) begin
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            prod_in  = mul_p;
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            prod_in  = mul_p;
            acc_in   = {1'b0, prod_ff};
            state_in = ST_MUL_R;
         end
         ST_MUL_R: begin
            prod_in  = mul_p;
            acc_in   = acc_ff + {1'b0, prod_ff};
            state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = ST_CMP;
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_pnum_in  = qnum_ff;
            rsp_last_in  = 1'b1;
            if (pend_ff) begin
               rsp_status_in = STATUS_INSIDE;
               rsp_fig_in    = FIG_NUM_W'(pend_fig_ff);
            end else begin
               rsp_status_in = STATUS_OUTSIDE;
               rsp_fig_in    = '0;
            end
            state_in = ST_IDLE;
         end
      endcase

      // Hold a hit back until the next hit or the end shows whether it is last
      if (eval_en) begin
         if (eval_hit) begin
            if (pend_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_INSIDE;
               rsp_pnum_in   = qnum_ff;
               rsp_fig_in    = FIG_NUM_W'(pend_fig_ff);
               rsp_last_in   = 1'b0;
            end
            pend_in     = 1'b1;
            pend_fig_in = idx_next_cnt;
         end
         if (idx_next_cnt == count_ff) begin
            state_in = ST_FINISH;
         end else begin
            idx_in   = IDX_W'(idx_next_cnt);
            state_in = ST_READ;
         end
      end
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         qnum_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         qnum_ff      <= qnum_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Advance payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pend_fig_ff   <= pend_fig_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pnum_ff   <= rsp_pnum_in;
      rsp_fig_ff    <= rsp_fig_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_point_number  = rsp_pnum_ff;
   assign rsp_figure_number = rsp_fig_ff;
   assign rsp_last          = rsp_last_ff;

endmodule
